/* design/rpsb_pkg.sv */
// -----------------------------------------------------------------------------
// rpsb_pkg
// Shared types and constants for the register producer scoreboard.
// -----------------------------------------------------------------------------
package rpsb_pkg;

	localparam int SEQ_W      = 63;
	localparam int SRC_FIELDS = 4;
	localparam int DST_FIELDS = 2;

	localparam int RPSB_NUM_REGS    = 256;
	localparam int RPSB_MAX_SOURCES = 4;
	localparam int RPSB_MAX_DESTS   = 2;

	// Item kinds
	localparam logic [1:0] KIND_DISPATCH = 2'd0;
	localparam logic [1:0] KIND_PEEK     = 2'd1;
	localparam logic [1:0] KIND_CLEAR    = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [SEQ_W-1:0] seq;
		logic [SEQ_W-1:0] low;
		logic [2:0]       src_count;
		logic [8:0]       src0;
		logic [7:0]       src1;
		logic [7:0]       src2;
		logic [7:0]       src3;
		logic [1:0]       dst_count;
		logic [7:0]       dst0;
		logic [7:0]       dst1;
	} rpsb_item_t;

	typedef struct packed {
		logic             has;
		logic [SEQ_W-1:0] seq;
		logic             last;
	} rpsb_res_t;

	// Table access controls from the sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic inval_en;
		logic clear_all;
	} rpsb_tbl_ctl_t;

endpackage

/* design/rpsb_table.sv */
// -----------------------------------------------------------------------------
// rpsb_table
// Producer sequence memory (single address, registered read) and valid bits.
// -----------------------------------------------------------------------------
module rpsb_table import rpsb_pkg::*; #(
	parameter int NUM_REGS = RPSB_NUM_REGS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rpsb_tbl_ctl_t               ctl,
	input  logic [$clog2(NUM_REGS)-1:0] addr,
	input  logic [SEQ_W-1:0]            wr_seq,
	output logic [SEQ_W-1:0]            rd_seq,
	output logic                        rd_valid
);

	logic [SEQ_W-1:0]    mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [SEQ_W-1:0]    rd_seq_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= wr_seq;
		end
		if (ctl.rd_en) begin
			rd_seq_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.clear_all) begin
				valid_q <= '0;
			end else if (ctl.inval_en) begin
				valid_q[addr] <= 1'b0;
			end else if (ctl.wr_en) begin
				valid_q[addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	assign rd_seq   = rd_seq_q;
	assign rd_valid = rd_valid_q;

endmodule

/* design/rpsb_ctrl.sv */
// -----------------------------------------------------------------------------
// rpsb_ctrl
// Sequencer: walks the sources through one lookup and compare unit, then
// writes the destinations one per cycle.
// -----------------------------------------------------------------------------
module rpsb_ctrl import rpsb_pkg::*; #(
	parameter int NUM_REGS    = RPSB_NUM_REGS,
	parameter int MAX_SOURCES = RPSB_MAX_SOURCES,
	parameter int MAX_DESTS   = RPSB_MAX_DESTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rpsb_item_t                  item,
	output logic                        push_valid,
	input  logic                        push_ready,
	output rpsb_res_t                   push_res,
	output rpsb_tbl_ctl_t               tbl_ctl,
	output logic [$clog2(NUM_REGS)-1:0] tbl_addr,
	output logic [SEQ_W-1:0]            tbl_wr_seq,
	input  logic [SEQ_W-1:0]            tbl_rd_seq,
	input  logic                        tbl_rd_valid
);

	localparam int IDX_W   = $clog2(NUM_REGS);
	localparam int SRC_LIM = (MAX_SOURCES < SRC_FIELDS) ? MAX_SOURCES : SRC_FIELDS;
	localparam int DST_LIM = (MAX_DESTS < DST_FIELDS) ? MAX_DESTS : DST_FIELDS;
	localparam logic [2:0]  SRC_LIM_L = 3'(SRC_LIM);
	localparam logic [1:0]  DST_LIM_L = 2'(DST_LIM);
	localparam logic [10:0] NREG_L    = 11'(NUM_REGS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_FINAL = 3'd3;
	localparam logic [2:0] S_DEST  = 3'd4;

	logic [2:0]       state_q;
	logic [1:0]       kind_q;
	logic [SEQ_W-1:0] seq_q;
	logic [SEQ_W-1:0] low_q;
	logic [8:0]       src_q [SRC_FIELDS];
	logic [SRC_FIELDS-1:0] src_ok_q;
	logic [7:0]       dst_q [DST_FIELDS];
	logic [DST_FIELDS-1:0] dst_ok_q;
	logic [2:0]       cnt_q;
	logic [1:0]       nd_q;
	logic [2:0]       idx_q;
	logic [1:0]       didx_q;
	logic             pend_valid_q;
	logic [SEQ_W-1:0] pend_seq_q;

	logic       accept;
	logic       ge;
	logic       live;
	logic       stale;
	logic       stall;
	logic       idx_last;
	logic       dest_last;
	logic [2:0] ns;
	logic [1:0] nd;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign ns        = (item.src_count > SRC_LIM_L) ? SRC_LIM_L : item.src_count;
	assign nd        = (item.dst_count > DST_LIM_L) ? DST_LIM_L : item.dst_count;

	// shared compare unit
	assign ge        = (tbl_rd_seq >= low_q);
	assign live      = src_ok_q[idx_q[1:0]] && tbl_rd_valid && ge;
	assign stale     = src_ok_q[idx_q[1:0]] && tbl_rd_valid && !ge
	                   && (kind_q == KIND_DISPATCH);
	assign stall     = live && pend_valid_q && !push_ready;
	assign idx_last  = ((idx_q + 3'd1) == cnt_q);
	assign dest_last = ((didx_q + 2'd1) == nd_q);
	assign tbl_wr_seq = seq_q;

	always_comb begin
		tbl_ctl       = '0;
		tbl_addr      = IDX_W'(src_q[idx_q[1:0]]);
		push_valid    = 1'b0;
		push_res.has  = 1'b1;
		push_res.seq  = pend_seq_q;
		push_res.last = 1'b0;
		case (state_q)
			S_IDLE: begin
				tbl_ctl.clear_all = accept && (item.kind == KIND_CLEAR);
			end
			S_LOOK: begin
				tbl_ctl.rd_en = 1'b1;
			end
			S_CMP: begin
				tbl_ctl.inval_en = stale;
				push_valid       = live && pend_valid_q;
			end
			S_FINAL: begin
				push_valid    = 1'b1;
				push_res.has  = pend_valid_q;
				push_res.seq  = pend_valid_q ? pend_seq_q : '0;
				push_res.last = 1'b1;
			end
			S_DEST: begin
				tbl_addr       = IDX_W'(dst_q[didx_q[0]]);
				tbl_ctl.wr_en  = dst_ok_q[didx_q[0]];
			end
			default: begin
				tbl_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= KIND_DISPATCH;
			cnt_q        <= '0;
			nd_q         <= '0;
			idx_q        <= '0;
			didx_q       <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q       <= item.kind;
						idx_q        <= '0;
						didx_q       <= '0;
						pend_valid_q <= 1'b0;
						nd_q         <= nd;
						case (item.kind)
							KIND_DISPATCH: begin
								cnt_q   <= ns;
								state_q <= (ns == 3'd0) ? S_FINAL : S_LOOK;
							end
							KIND_PEEK: begin
								cnt_q   <= 3'd1;
								state_q <= S_LOOK;
							end
							KIND_CLEAR: begin
								state_q <= S_FINAL;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_LOOK: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!stall) begin
						if (live) begin
							pend_valid_q <= 1'b1;
						end
						idx_q   <= idx_q + 3'd1;
						state_q <= idx_last ? S_FINAL : S_LOOK;
					end
				end
				S_FINAL: begin
					if (push_ready) begin
						if (kind_q == KIND_DISPATCH && nd_q != 2'd0) begin
							state_q <= S_DEST;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DEST: begin
					didx_q  <= didx_q + 2'd1;
					state_q <= dest_last ? S_IDLE : S_DEST;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: capture the item, track the pending dependency
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q       <= item.seq;
			low_q       <= item.low;
			src_q[0]    <= item.src0;
			src_q[1]    <= {1'b0, item.src1};
			src_q[2]    <= {1'b0, item.src2};
			src_q[3]    <= {1'b0, item.src3};
			src_ok_q[0] <= ({2'b00, item.src0} < NREG_L);
			src_ok_q[1] <= ({3'b000, item.src1} < NREG_L);
			src_ok_q[2] <= ({3'b000, item.src2} < NREG_L);
			src_ok_q[3] <= ({3'b000, item.src3} < NREG_L);
			dst_q[0]    <= item.dst0;
			dst_q[1]    <= item.dst1;
			dst_ok_q[0] <= ({3'b000, item.dst0} < NREG_L);
			dst_ok_q[1] <= ({3'b000, item.dst1} < NREG_L);
		end
		if (state_q == S_CMP && !stall && live) begin
			pend_seq_q <= tbl_rd_seq;
		end
	end

endmodule

/* design/register_producer_scoreboard_unit.sv */
// -----------------------------------------------------------------------------
// register_producer_scoreboard_unit
// Tracks the last writer of each architectural register for dispatch.
//
// One beat in carries a dispatch, a peek or a clear (tuser). A dispatch looks
// up its sources in order and sends one beat per live producer, or one beat
// with has_producer low when there is none; tlast marks the final beat. Then
// its destinations record the dispatch's sequence number. Producers older
// than lowest_valid count as retired and a dispatch drops their valid mark;
// a peek only reports. A clear drops every valid mark and sends one
// acknowledge beat. The block takes one item at a time and accepts no new
// item until it is back in idle. The sources of a dispatch or peek go in
// turn through the single table read port and compare unit, and the
// destinations are then written one after another.
// Results sit in an output register, so a waiting result does not block
// the sequencer until the next one is ready to go out. No clearing pass
// follows reset; the valid marks clear at once.
// -----------------------------------------------------------------------------
module register_producer_scoreboard_unit import rpsb_pkg::*; #(
	parameter int NUM_REGS    = RPSB_NUM_REGS,
	parameter int MAX_SOURCES = RPSB_MAX_SOURCES,
	parameter int MAX_DESTS   = RPSB_MAX_DESTS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// sequence_number[62:0], lowest_valid[125:63], source_count[128:126],
	// source_reg_0[137:129], source_reg_1[145:138], source_reg_2[153:146],
	// source_reg_3[161:154], dest_count[163:162], dest_reg_0[171:164],
	// dest_reg_1[179:172], zero pad[183:180]
	input  logic [183:0] s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// producer_seq[62:0], zero pad[63]
	output logic [63:0]  m_axis_tdata,
	// has_producer[0]
	output logic         m_axis_tuser,
	output logic         m_axis_tlast
);

	localparam int IDX_W = $clog2(NUM_REGS);

	rpsb_item_t       item;
	rpsb_res_t        push_res;
	rpsb_res_t        out_res_q;
	rpsb_tbl_ctl_t    tbl_ctl;
	logic [IDX_W-1:0] tbl_addr;
	logic [SEQ_W-1:0] tbl_wr_seq;
	logic [SEQ_W-1:0] tbl_rd_seq;
	logic             tbl_rd_valid;
	logic             push_valid;
	logic             push_ready;
	logic             out_valid_q;

	// unpack the input beat
	assign item.kind      = s_axis_tuser;
	assign item.seq       = s_axis_tdata[62:0];
	assign item.low       = s_axis_tdata[125:63];
	assign item.src_count = s_axis_tdata[128:126];
	assign item.src0      = s_axis_tdata[137:129];
	assign item.src1      = s_axis_tdata[145:138];
	assign item.src2      = s_axis_tdata[153:146];
	assign item.src3      = s_axis_tdata[161:154];
	assign item.dst_count = s_axis_tdata[163:162];
	assign item.dst0      = s_axis_tdata[171:164];
	assign item.dst1      = s_axis_tdata[179:172];

	rpsb_ctrl #(
		.NUM_REGS    (NUM_REGS),
		.MAX_SOURCES (MAX_SOURCES),
		.MAX_DESTS   (MAX_DESTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.item         (item),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_res     (push_res),
		.tbl_ctl      (tbl_ctl),
		.tbl_addr     (tbl_addr),
		.tbl_wr_seq   (tbl_wr_seq),
		.tbl_rd_seq   (tbl_rd_seq),
		.tbl_rd_valid (tbl_rd_valid)
	);

	rpsb_table #(
		.NUM_REGS (NUM_REGS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tbl_ctl),
		.addr     (tbl_addr),
		.wr_seq   (tbl_wr_seq),
		.rd_seq   (tbl_rd_seq),
		.rd_valid (tbl_rd_valid)
	);

	// Output register: load when empty or when the held beat leaves this cycle.
	assign push_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_valid && push_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			out_res_q <= push_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_res_q.seq};
	assign m_axis_tuser  = out_res_q.has;
	assign m_axis_tlast  = out_res_q.last;

`ifndef SYNTHESIS
	// the sequencer never offers a result while it can take a new item
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !push_valid)
		else $error("result offered while sequencer idle");

	// a refused result is offered again on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> push_valid)
		else $error("refused result dropped");

	// a table entry is never invalidated and written in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!(tbl_ctl.inval_en && tbl_ctl.wr_en))
		else $error("invalidate and write collide");

	// the whole table clears only on an accepted beat
	assert property (@(posedge clk) disable iff (!arst_n)
		tbl_ctl.clear_all |-> (s_axis_tvalid && s_axis_tready))
		else $error("clear without accepted beat");
`endif

endmodule
